### hdl/stis_pkg.sv
// Shared constants, types and helpers of the sorted table unit.
package stis_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned POS_W       = 6;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
  } res_t;

  // Reported position keeps only the low POS_W bits of the index.
  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] idx);
    logic [CNT_W+POS_W-1:0] ext;
    ext = {{POS_W{1'b0}}, idx};
    return ext[POS_W-1:0];
  endfunction

endpackage

### hdl/sorted_table_insert_search_unit.sv
// Clear, an insert into a full or an empty table and unused commands go straight to the
// result; other inserts first shift the larger entries up one place each, and search
// probes the table by binary search until the key is found or the range is empty.
// One item is in work at a time; the next word is taken the cycle after the result moves
// to the output register, even while it waits there. Reset empties the table; RAM
// contents stay undefined.
module sorted_table_insert_search_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [stis_pkg::CMD_W-1:0]         command_i,
  input  logic signed [stis_pkg::VAL_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [stis_pkg::STAT_W-1:0]        status_o,
  output logic [stis_pkg::POS_W-1:0]         position_o
);
  import stis_pkg::*;

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic [CNT_W-1:0] entry_count;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  logic             out_valid_q;
  res_t             out_res_q;

  stis_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .entry_count_o (entry_count),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  stis_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // hold the word until taken; refill in the same cycle it leaves
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
        out_res_q   <= res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_res_q.status;
  assign position_o  = out_res_q.position;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new word taken while previous one still in work");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !out_valid_q |=> out_valid_q)
    else $error("finished result not moved to output register");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_NOT_FOUND) |-> position_o == '0)
    else $error("nonzero position with full or not-found status");

endmodule

### hdl/stis_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/stis_seq.sv
// Command sequencer: clear, insertion shifts and binary search over the table RAM.
module stis_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [stis_pkg::CMD_W-1:0]          command_i,
  input  logic signed [stis_pkg::VAL_W-1:0]   value_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output stis_pkg::res_t                      res_o,
  output logic [stis_pkg::CNT_W-1:0]          entry_count_o,
  output logic                                mem_we_o,
  output logic [stis_pkg::IDX_W-1:0]          mem_waddr_o,
  output logic [stis_pkg::VAL_W-1:0]          mem_wdata_o,
  output logic [stis_pkg::IDX_W-1:0]          mem_raddr_o,
  input  logic [stis_pkg::VAL_W-1:0]          mem_rdata_i
);
  import stis_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_SRCH_PROBE,
    S_SRCH_CMP,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         pos_q;
  logic [CNT_W-1:0]         lo_q;
  logic [CNT_W-1:0]         hp1_q;
  logic [IDX_W-1:0]         mid_q;
  logic signed [VAL_W-1:0]  val_q;
  res_t                     res_q;

  logic                     accept;
  logic                     full;
  logic [CNT_W-1:0]         cnt_m1;
  logic [CNT_W-1:0]         pos_m1;
  logic [CNT_W-1:0]         pos_m2;
  logic [CNT_W:0]           mid_sum;
  logic [CNT_W-1:0]         mid_full;
  logic [IDX_W-1:0]         mid_idx;
  logic signed [VAL_W-1:0]  rdata_s;
  logic                     greater;

  assign accept   = in_valid_i && in_ready_o;
  assign full     = (count_q == CNT_W'(TABLE_DEPTH));
  assign cnt_m1   = count_q - CNT_W'(1);
  assign pos_m1   = pos_q - CNT_W'(1);
  assign pos_m2   = pos_q - CNT_W'(2);
  // midpoint of [lo, hp1-1]; only meaningful while lo < hp1
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hp1_q} - (CNT_W+1)'(1);
  assign mid_full = mid_sum[CNT_W:1];
  assign mid_idx  = mid_full[IDX_W-1:0];
  assign rdata_s  = $signed(mem_rdata_i);
  assign greater  = (rdata_s > val_q);

  assign in_ready_o    = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_DONE);
  assign res_o         = res_q;
  assign entry_count_o = count_q;

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q[IDX_W-1:0];
    mem_wdata_o = val_q;
    mem_raddr_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && command_i == CMD_INSERT && !full) begin
          if (count_q == '0) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = '0;
            mem_wdata_o = value_i;
          end else begin
            mem_raddr_o = cnt_m1[IDX_W-1:0];
          end
        end
      end
      S_INS_CMP: begin
        mem_we_o = 1'b1;
        if (greater) begin
          // shift the larger entry up and fetch the next one below
          mem_wdata_o = mem_rdata_i;
          mem_raddr_o = pos_m2[IDX_W-1:0];
        end
      end
      S_INS_PUT:    mem_we_o = 1'b1;
      S_SRCH_PROBE: mem_raddr_o = mid_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            val_q          <= value_i;
            res_q.status   <= ST_OK;
            res_q.position <= '0;
            state_q        <= S_DONE;
            unique case (command_i)
              CMD_CLEAR: count_q <= '0;
              CMD_INSERT: begin
                if (full) begin
                  res_q.status <= ST_FULL;
                end else if (count_q == '0) begin
                  count_q <= CNT_W'(1);
                end else begin
                  pos_q   <= count_q;
                  state_q <= S_INS_CMP;
                end
              end
              CMD_SEARCH: begin
                lo_q    <= '0;
                hp1_q   <= count_q;
                state_q <= S_SRCH_PROBE;
              end
              default: ;
            endcase
          end
        end
        S_INS_CMP: begin
          if (greater) begin
            pos_q <= pos_m1;
            if (pos_m1 == '0) begin
              state_q <= S_INS_PUT;
            end
          end else begin
            count_q        <= count_q + CNT_W'(1);
            res_q.position <= to_pos(pos_q);
            state_q        <= S_DONE;
          end
        end
        S_INS_PUT: begin
          count_q        <= count_q + CNT_W'(1);
          res_q.position <= to_pos(pos_q);
          state_q        <= S_DONE;
        end
        S_SRCH_PROBE: begin
          if (lo_q < hp1_q) begin
            mid_q   <= mid_idx;
            state_q <= S_SRCH_CMP;
          end else begin
            res_q.status <= ST_NOT_FOUND;
            state_q      <= S_DONE;
          end
        end
        S_SRCH_CMP: begin
          if (rdata_s == val_q) begin
            res_q.position <= to_pos(CNT_W'(mid_q));
            state_q        <= S_DONE;
          end else begin
            if (val_q > rdata_s) begin
              lo_q <= CNT_W'(mid_q) + CNT_W'(1);
            end else begin
              hp1_q <= CNT_W'(mid_q);
            end
            state_q <= S_SRCH_PROBE;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
